// File: design/assert_macros.svh
// Assertion macros shared by the cipher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition leads to a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);

`endif

// File: design/rc4_pkg.sv
// Types and constants shared by the stream cipher modules.
package rc4_pkg;

   localparam int SBOX_SIZE = 256;
   localparam int SBOX_AW   = 8;

   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_KA,
      ST_KB,
      ST_KC,
      ST_KD
   } rc4_state_type;

   typedef struct packed {
      logic               we;
      logic [SBOX_AW-1:0] waddr;
      logic [7:0]         wdata;
      logic [SBOX_AW-1:0] raddr;
      logic               clear;
   } sbox_cmd_type;

endpackage

// File: design/rc4_stream_if.sv
// Handshake interfaces for the request and response channels.
interface rc4_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;
   logic       key_last;

   modport source (output valid, output cmd, output data_byte, output key_last, input ready);
   modport sink (input valid, input cmd, input data_byte, input key_last, output ready);
endinterface

interface rc4_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink (input valid, input out_byte, output ready);
endinterface

// File: design/rc4_sbox_ram.sv
// Permutation memory with per-entry valid bits; an invalid entry reads as its own index.
`include "assert_macros.svh"

module rc4_sbox_ram
   import rc4_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  sbox_cmd_type       cmd,
   output logic [7:0]         rdata
);

   logic [7:0]           mem [SBOX_SIZE];
   logic [SBOX_SIZE-1:0] valid_ff;
   logic [7:0]           rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.we) begin
         valid_ff[cmd.waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
      rdata_ff <= valid_ff[cmd.raddr] ? mem[cmd.raddr] : cmd.raddr;
   end

   assign rdata = rdata_ff;

   `ASSERT_CLK(a_clear_no_write, !(cmd.clear && cmd.we), "permutation cleared while written")

endmodule

// File: design/rc4_key_ram.sv
// Key byte store with one write port and one registered read port.
module rc4_key_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/rc4_stream_cipher_unit.sv
// Top level of the stream cipher: sequencer, index arithmetic and output register.
// A key beat is taken and stored while fewer than MAX_KEY_BYTES bytes are held; the key
// beat marked last then runs the key schedule, 256 swap steps through ST_KA to ST_KD, with
// ready low throughout. A data beat runs ST_P1, ST_P2, ST_P3 to its result in the output
// register, an order set by the dependent reads and two swap writes on the single
// permutation memory; a new beat is taken only back in ST_IDLE, after the last one is done.
// A data beat waits in ST_P3 while an earlier result has not been taken.
`include "assert_macros.svh"

module rc4_stream_cipher_unit
   import rc4_pkg::*;
#(
   parameter int MAX_KEY_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   rc4_req_if.sink      req_chan,
   rc4_rsp_if.source    rsp_chan
);

   localparam int KCW = $clog2(MAX_KEY_BYTES + 1);
   localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

   rc4_state_type      state_ff, state_in;
   logic [SBOX_AW-1:0] idx_i_ff, idx_i_in;
   logic [SBOX_AW-1:0] idx_j_ff, idx_j_in;
   logic [KCW-1:0]     key_count_ff, key_count_in;
   logic [KCW-1:0]     klen_ff, klen_in;
   logic [KAW-1:0]     kidx_ff, kidx_in;
   logic [7:0]         si_ff, si_in;
   logic [7:0]         sj_ff, sj_in;
   logic [SBOX_AW-1:0] t_ff, t_in;
   logic [7:0]         data_ff, data_in;
   logic [7:0]         out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   sbox_cmd_type       sbox_cmd;
   logic [7:0]         sbox_rdata;
   logic               key_we;
   logic [7:0]         key_rdata;
   logic [KCW-1:0]     count_after;
   logic [KCW-1:0]     kidx_next;
   logic [7:0]         ks_byte;
   logic               req_accept;

   rc4_sbox_ram u_sbox (
      .clock (clock),
      .reset (reset),
      .cmd   (sbox_cmd),
      .rdata (sbox_rdata)
   );

   rc4_key_ram #(
      .DEPTH (MAX_KEY_BYTES),
      .AW    (KAW)
   ) u_key (
      .clock (clock),
      .we    (key_we),
      .waddr (key_count_ff[KAW-1:0]),
      .wdata (req_chan.data_byte),
      .raddr (kidx_ff),
      .rdata (key_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_i_ff     <= '0;
         idx_j_ff     <= '0;
         key_count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_i_ff     <= idx_i_in;
         idx_j_ff     <= idx_j_in;
         key_count_ff <= key_count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      klen_ff <= klen_in;
      kidx_ff <= kidx_in;
      si_ff   <= si_in;
      sj_ff   <= sj_in;
      t_ff    <= t_in;
      data_ff <= data_in;
      out_ff  <= out_in;
   end

   assign count_after = (key_count_ff < KCW'(MAX_KEY_BYTES)) ? key_count_ff + 1'b1
                                                             : key_count_ff;
   assign kidx_next   = KCW'(kidx_ff) + 1'b1;

   always_comb begin
      if (t_ff == idx_j_ff) begin
         ks_byte = si_ff;
      end else if (t_ff == idx_i_ff) begin
         ks_byte = sj_ff;
      end else begin
         ks_byte = sbox_rdata;
      end
   end

   assign req_accept = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in       = state_ff;
      idx_i_in       = idx_i_ff;
      idx_j_in       = idx_j_ff;
      key_count_in   = key_count_ff;
      klen_in        = klen_ff;
      kidx_in        = kidx_ff;
      si_in          = si_ff;
      sj_in          = sj_ff;
      t_in           = t_ff;
      data_in        = data_ff;
      out_in         = out_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      key_we         = 1'b0;
      req_chan.ready = 1'b0;
      sbox_cmd.we    = 1'b0;
      sbox_cmd.waddr = idx_i_ff;
      sbox_cmd.wdata = sj_ff;
      sbox_cmd.raddr = idx_i_ff + 1'b1;
      sbox_cmd.clear = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_accept) begin
               if (req_chan.cmd == CMD_DATA) begin
                  idx_i_in = idx_i_ff + 1'b1;
                  data_in  = req_chan.data_byte;
                  state_in = ST_P1;
               end else begin
                  key_we       = key_count_ff < KCW'(MAX_KEY_BYTES);
                  key_count_in = count_after;
                  if (req_chan.key_last) begin
                     klen_in        = count_after;
                     key_count_in   = '0;
                     kidx_in        = '0;
                     idx_i_in       = '0;
                     idx_j_in       = '0;
                     sbox_cmd.clear = 1'b1;
                     state_in       = ST_KA;
                  end
               end
            end
         end
         ST_P1: begin
            si_in          = sbox_rdata;
            idx_j_in       = idx_j_ff + sbox_rdata;
            sbox_cmd.raddr = idx_j_ff + sbox_rdata;
            state_in       = ST_P2;
         end
         ST_P2: begin
            sj_in          = sbox_rdata;
            t_in           = si_ff + sbox_rdata;
            sbox_cmd.we    = 1'b1;
            sbox_cmd.waddr = idx_i_ff;
            sbox_cmd.wdata = sbox_rdata;
            sbox_cmd.raddr = si_ff + sbox_rdata;
            state_in       = ST_P3;
         end
         ST_P3: begin
            sbox_cmd.we    = 1'b1;
            sbox_cmd.waddr = idx_j_ff;
            sbox_cmd.wdata = si_ff;
            sbox_cmd.raddr = t_ff;
            if (!out_valid_ff || rsp_chan.ready) begin
               out_in       = data_ff ^ ks_byte;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_KA: begin
            sbox_cmd.raddr = idx_i_ff;
            state_in       = ST_KB;
         end
         ST_KB: begin
            si_in          = sbox_rdata;
            idx_j_in       = idx_j_ff + sbox_rdata + key_rdata;
            sbox_cmd.raddr = idx_j_ff + sbox_rdata + key_rdata;
            state_in       = ST_KC;
         end
         ST_KC: begin
            sj_in          = sbox_rdata;
            sbox_cmd.we    = 1'b1;
            sbox_cmd.waddr = idx_i_ff;
            sbox_cmd.wdata = sbox_rdata;
            state_in       = ST_KD;
         end
         ST_KD: begin
            sbox_cmd.we    = 1'b1;
            sbox_cmd.waddr = idx_j_ff;
            sbox_cmd.wdata = si_ff;
            idx_i_in       = idx_i_ff + 1'b1;
            kidx_in        = (kidx_next == klen_ff) ? '0 : kidx_next[KAW-1:0];
            if (idx_i_ff == SBOX_AW'(SBOX_SIZE - 1)) begin
               idx_i_in = '0;
               idx_j_in = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KA;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_byte = out_ff;

   `ASSERT_CLK(a_idle_no_write, (state_ff == ST_IDLE) |-> !sbox_cmd.we, "permutation written while idle")
   `ASSERT_NEXT(a_last_key_busy, req_accept && (req_chan.cmd == CMD_KEY) && req_chan.key_last, !req_chan.ready, "ready during key schedule")
   `ASSERT_CLK(a_rsp_from_p3, $rose(rsp_chan.valid) |-> $past(state_ff == ST_P3), "result appeared outside final data step")
   `ASSERT_CLK(a_kidx_in_range, (state_ff == ST_KA || state_ff == ST_KB || state_ff == ST_KC || state_ff == ST_KD) |-> (KCW'(kidx_ff) < klen_ff), "key index beyond key length")

endmodule
